FILE: rtl/core/sosc_pkg.sv
`timescale 1ns / 1ps

package sosc_pkg;

  // Register map
  localparam int REG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [REG_INDEX_W-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [REG_INDEX_W-1:0] REG_AMPLITUDE  = 1'd1;

  // Field widths
  localparam int STEP_W   = 32;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int Q_FRAC   = 30;
  localparam int MAG_W    = Q_FRAC + 1;   // magnitude spans [0, 1.0] in Q30

  localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 17'sd32767;
  localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -17'sd32768;

  // Odd polynomial for sin(pi/2 * t), Q30 coefficients
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint C1  = 64'sd1686629713;
  localparam longint C3  = -64'sd693598670;
  localparam longint C5  = 64'sd85569306;
  localparam longint C7  = -64'sd5026995;
  localparam longint C9  = 64'sd172272;
  localparam longint C11 = -64'sd3864;
  localparam longint C13 = 64'sd61;

  // Q30 product truncated toward zero
  function automatic longint qmul(longint a, longint b);
    logic   neg;
    longint ua;
    longint ub;
    longint m;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    m   = (ua * ub) >>> Q_FRAC;
    return neg ? -m : m;
  endfunction

  // Quarter-wave magnitude at step r of 2^qbits per quarter turn.
  // Only evaluated at elaboration to build the ROM contents.
  function automatic logic [MAG_W-1:0] quarter_mag(int qbits, longint r);
    longint t;
    longint u;
    longint acc;
    t   = r <<< (Q_FRAC - qbits);
    u   = qmul(t, t);
    acc = C13;
    acc = qmul(acc, u) + C11;
    acc = qmul(acc, u) + C9;
    acc = qmul(acc, u) + C7;
    acc = qmul(acc, u) + C5;
    acc = qmul(acc, u) + C3;
    acc = qmul(acc, u) + C1;
    acc = qmul(acc, t);
    if (acc < 0) acc = 0;
    if (acc > Q30_ONE) acc = Q30_ONE;
    return MAG_W'(acc);
  endfunction

endpackage

FILE: rtl/core/sosc_tick_if.sv
`timescale 1ns / 1ps

interface sosc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

FILE: rtl/core/sosc_sample_if.sv
`timescale 1ns / 1ps

interface sosc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/sosc_sine_rom.sv
`timescale 1ns / 1ps

module sosc_sine_rom #(
  parameter int QBITS = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [QBITS:0]               addr,
  output logic [sosc_pkg::MAG_W-1:0]   data
);
  import sosc_pkg::*;

  localparam int DEPTH = (1 << QBITS) + 1;

  // Quarter wave including the endpoint at a full quarter turn
  logic [MAG_W-1:0] rom_table [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    assign rom_table[i] = quarter_mag(QBITS, longint'(i));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom_table[addr];
    end
  end

endmodule

FILE: rtl/core/sine_oscillator.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload               Meaning
// ticks     in   tick   (1b)           request one sample; tick=0 is taken and dropped
// samples   out  sample (16b signed)   amplitude * sin(phase)
// write_*   in   index 1b, data 32b    0: phase_step, 1: amplitude
//
// Two-stage pipeline: a taken tick is registered into stage 1 (the ROM read), then
// its sample into stage 2; one sample per cycle is sustained while samples.ready holds.
// The sine ROM's registered read sets the first stage, the 15x31 multiply and
// sign/clamp set the second.
// Reset clears phase, the configuration registers and stage valids.
// A stalled output holds both stages; ticks are still taken while stage 1 is empty.

module sine_oscillator #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  sosc_tick_if.sink                           ticks,
  sosc_sample_if.source                       samples,
  input  logic                                write_en,
  input  logic [sosc_pkg::REG_INDEX_W-1:0]    write_index,
  input  logic [sosc_pkg::CFG_DATA_W-1:0]     write_data
);
  import sosc_pkg::*;

  localparam int QBITS  = TABLE_ADDR_BITS - 2;
  localparam int PROD_W = AMP_W + MAG_W;

  // Configuration registers
  logic [STEP_W-1:0] phase_step;
  logic [AMP_W-1:0]  amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      amplitude  <= '0;
    end else if (write_en) begin
      case (write_index)
        REG_PHASE_STEP: phase_step <= write_data[STEP_W-1:0];
        REG_AMPLITUDE:  amplitude  <= write_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage moves when it is empty or the one after it is free or moving
  logic v1;
  logic v2;
  logic adv1;
  logic adv2;
  logic fire;
  logic live;

  assign adv2 = !v2 || samples.ready;
  assign adv1 = !v1 || adv2;
  assign ticks.ready = adv1;
  assign fire = ticks.valid && ticks.ready;
  // A zero tick is consumed but yields no word and leaves the phase alone
  assign live = fire && ticks.tick;

  // Step aligned to the accumulator width
  logic [PHASE_BITS-1:0] step_aligned;

  if (PHASE_BITS >= STEP_W) begin : g_step_up
    assign step_aligned = PHASE_BITS'(phase_step) << (PHASE_BITS - STEP_W);
  end else begin : g_step_dn
    assign step_aligned = phase_step[STEP_W-1 -: PHASE_BITS];
  end

  // Phase accumulator wraps modulo one turn
  logic [PHASE_BITS-1:0] phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (live) begin
      phase <= phase + step_aligned;
    end
  end

  // Table address: quadrant in the top two bits, mirror odd quadrants
  logic [TABLE_ADDR_BITS-1:0] tab_addr;
  logic [1:0]                 quad;
  logic [QBITS:0]             rom_addr;
  localparam logic [QBITS:0]  QUARTER = {1'b1, {QBITS{1'b0}}};

  assign tab_addr = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign quad     = tab_addr[TABLE_ADDR_BITS-1 -: 2];
  assign rom_addr = quad[0] ? (QUARTER - {1'b0, tab_addr[QBITS-1:0]})
                            : {1'b0, tab_addr[QBITS-1:0]};

  // Stage 1: ROM read, carry the sign alongside
  logic [MAG_W-1:0] rom_mag;
  logic             neg1;

  sosc_sine_rom #(
    .QBITS (QBITS)
  ) u_rom (
    .clk  (clk),
    .en   (adv1),
    .addr (rom_addr),
    .data (rom_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      neg1 <= quad[1];
    end
  end

  // Stage 2: scale by amplitude, truncate, apply sign, clamp
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-Q_FRAC-1:0]   mag;
  logic signed [SAMPLE_W:0]   signed_val;
  logic signed [SAMPLE_W:0]   sat_val;
  logic signed [SAMPLE_W-1:0] sample_r;

  assign prod = PROD_W'(amplitude) * PROD_W'(rom_mag);
  assign mag  = prod[PROD_W-1:Q_FRAC];

  always_comb begin
    signed_val = neg1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (signed_val > SAMPLE_MAX) begin
      sat_val = SAMPLE_MAX;
    end else if (signed_val < SAMPLE_MIN) begin
      sat_val = SAMPLE_MIN;
    end else begin
      sat_val = signed_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      sample_r <= sat_val[SAMPLE_W-1:0];
    end
  end

  assign samples.valid  = v2;
  assign samples.sample = sample_r;

  // Magnitude of the word on the output, for checking against amplitude
  logic [SAMPLE_W:0] sample_abs;
  assign sample_abs = sample_r[SAMPLE_W-1] ? -{sample_r[SAMPLE_W-1], sample_r}
                                           : {sample_r[SAMPLE_W-1], sample_r};

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !live |=> phase == $past(phase))
    else $error("phase moved without a live tick");

  a_stage1_fill: assert property (@(posedge clk) disable iff (rst)
    live |=> v1)
    else $error("live tick did not reach stage 1");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv2 |=> v1)
    else $error("stage 1 dropped a word while stage 2 stalled");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> sample_abs <= {2'b00, amplitude})
    else $error("sample magnitude exceeds amplitude");

endmodule
